// File: hw/rtl/gpc_pkg.sv
// Package for the grid path counter.
// Holds the configuration register codes and field widths shared by the interfaces and top level.
// Depends on nothing.
package gpc_pkg;

   // Configuration port widths.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 9;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GRID_ROWS  = 2'd0,
      CSR_GRID_COLS  = 2'd1,
      CSR_UNUSED_TWO = 2'd2,
      CSR_UNUSED_THR = 2'd3
   } csr_index_type;

endpackage

// File: hw/rtl/gpc_if.sv
// Channel interfaces of the grid path counter: cell input, result output, configuration.
// Depends on gpc_pkg.

// Input channel: one cell item per handshake.
interface gpc_req_if;
   logic valid;
   logic ready;
   logic blocked;

   modport source (output valid, output blocked, input ready);
   modport sink (input valid, input blocked, output ready);
endinterface

// Result channel: one count item per grid.
interface gpc_rsp_if #(
   parameter int COUNT_BITS = 64
);
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] path_count;
   logic                  saturated;

   modport source (output valid, output path_count, output saturated, input ready);
   modport sink (input valid, input path_count, input saturated, output ready);
endinterface

// Configuration write channel.
interface gpc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [gpc_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [gpc_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/grid_path_count_blocked.sv
// Top level of the grid path counter: control, adder and result register.
// Depends on gpc_pkg, gpc_if and gpc_row_chain.

// Counts right/down paths through a grid of open and blocked cells that arrive
// one item per cell in row-major order. The block takes one cell per clock
// cycle; each cell costs one read of the last stage of the row buffer chain,
// one COUNT_BITS-wide add with saturation and one shift of the chain. When the
// last cell of a grid arrives the count goes to an output register and the
// next grid may begin on the following cycle. Input is held off only when a
// last cell arrives while the previous grid's result still waits to be taken.
// Writing grid_rows or grid_cols restarts the current grid. The row buffer
// needs no clearing after reset, since an entry is read only after it was
// written in the row before.
module grid_path_count_blocked #(
   parameter int MAX_COLS   = 256,
   parameter int MAX_ROWS   = 256,
   parameter int COUNT_BITS = 64
) (
   input  logic           clock,
   input  logic           reset,
   gpc_req_if.sink        req_if,
   gpc_rsp_if.source      rsp_if,
   gpc_csr_if.sink        csr_if
);

   localparam int COL_BITS = $clog2(MAX_COLS);
   localparam int ROW_BITS = $clog2(MAX_ROWS);

   // Configuration and position state.
   logic [ROW_BITS-1:0]   rows_last_ff, rows_last_in;
   logic [COL_BITS-1:0]   cols_last_ff, cols_last_in;
   logic [COL_BITS-1:0]   insert_ff, insert_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [COUNT_BITS-1:0] left_ff, left_in;
   logic                  ovf_ff, ovf_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   logic                  csr_write;
   logic                  restart_cfg;
   logic [31:0]           csr_value;
   logic                  req_accept;
   logic                  last_cell;
   logic [COUNT_BITS-1:0] up_value;
   logic [COUNT_BITS-1:0] left_value;
   logic [COUNT_BITS:0]   sum;
   logic                  sum_over;
   logic [COUNT_BITS-1:0] cell_value;
   logic                  cell_ovf;
   logic [COUNT_BITS-1:0] chain_out;

   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid && csr_if.ready;
   assign csr_value    = 32'(csr_if.data);

   // Last cell of the grid, known from position alone.
   assign last_cell = (row_ff == rows_last_ff) && (col_ff == cols_last_ff);

   // Hold input only when a result would meet a full output register.
   assign req_if.ready = !(last_cell && rsp_valid_ff && !rsp_if.ready);
   assign req_accept   = req_if.valid && req_if.ready;

   // Cell arithmetic: above plus left, saturating.
   assign up_value   = (row_ff != '0) ? chain_out : '0;
   assign left_value = (col_ff != '0) ? left_ff : '0;
   assign sum        = {1'b0, up_value} + {1'b0, left_value};
   assign sum_over   = sum[COUNT_BITS];

   always_comb begin
      cell_ovf = 1'b0;
      if (req_if.blocked) begin
         cell_value = '0;
      end else if ((row_ff == '0) && (col_ff == '0)) begin
         cell_value = COUNT_BITS'(1);
      end else if (sum_over) begin
         cell_value = '1;
         cell_ovf   = 1'b1;
      end else begin
         cell_value = sum[COUNT_BITS-1:0];
      end
   end

   // Configuration decode with dimension clamping.
   always_comb begin
      rows_last_in = rows_last_ff;
      cols_last_in = cols_last_ff;
      restart_cfg  = 1'b0;
      if (csr_write) begin
         unique case (csr_if.index)
            gpc_pkg::CSR_GRID_ROWS: begin
               restart_cfg = 1'b1;
               if (csr_value == 32'd0) begin
                  rows_last_in = '0;
               end else if (csr_value > 32'(MAX_ROWS)) begin
                  rows_last_in = ROW_BITS'(MAX_ROWS - 1);
               end else begin
                  rows_last_in = ROW_BITS'(csr_value - 32'd1);
               end
            end
            gpc_pkg::CSR_GRID_COLS: begin
               restart_cfg = 1'b1;
               if (csr_value == 32'd0) begin
                  cols_last_in = '0;
               end else if (csr_value > 32'(MAX_COLS)) begin
                  cols_last_in = COL_BITS'(MAX_COLS - 1);
               end else begin
                  cols_last_in = COL_BITS'(csr_value - 32'd1);
               end
            end
            default: begin
               restart_cfg = 1'b0;
            end
         endcase
      end
      insert_in = COL_BITS'(MAX_COLS - 1) - cols_last_in;
   end

   // Position, left count and sticky flag.
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      left_in = left_ff;
      ovf_in  = ovf_ff;
      if (restart_cfg) begin
         row_in  = '0;
         col_in  = '0;
         left_in = '0;
         ovf_in  = 1'b0;
      end else if (req_accept) begin
         if (last_cell) begin
            row_in  = '0;
            col_in  = '0;
            left_in = '0;
            ovf_in  = 1'b0;
         end else begin
            left_in = cell_value;
            ovf_in  = ovf_ff || cell_ovf;
            if (col_ff == cols_last_ff) begin
               col_in = '0;
               row_in = row_ff + ROW_BITS'(1);
            end else begin
               col_in = col_ff + COL_BITS'(1);
            end
         end
      end
   end

   // Result register loads on the last cell and empties when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_count_in = rsp_count_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (req_accept && last_cell) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = cell_value;
         rsp_sat_in   = ovf_ff || cell_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_last_ff <= '0;
         cols_last_ff <= '0;
         insert_ff    <= COL_BITS'(MAX_COLS - 1);
         row_ff       <= '0;
         col_ff       <= '0;
         left_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_last_ff <= rows_last_in;
         cols_last_ff <= cols_last_in;
         insert_ff    <= insert_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         left_ff      <= left_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   // Row buffer: every accepted cell shifts its count into the chain.
   gpc_row_chain #(
      .DEPTH(MAX_COLS),
      .WIDTH(COUNT_BITS)
   ) u_row_chain (
      .clock     (clock),
      .shift_en  (req_accept),
      .insert_at (insert_ff),
      .din       (cell_value),
      .dout      (chain_out)
   );

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.path_count = rsp_count_ff;
   assign rsp_if.saturated  = rsp_sat_ff;

endmodule

// File: hw/rtl/gpc_cell.sv
// One cell of the row buffer chain: holds one count of the previous row.
// Depends on nothing.
module gpc_cell #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             shift_en,
   input  logic             load,
   input  logic [WIDTH-1:0] new_value,
   input  logic [WIDTH-1:0] prev_value,
   output logic [WIDTH-1:0] value
);

   logic [WIDTH-1:0] value_ff;
   logic [WIDTH-1:0] value_in;

   // On each shift the cell either takes the fresh count or its neighbor's count.
   assign value_in = load ? new_value : prev_value;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// File: hw/rtl/gpc_row_chain.sv
// Row buffer built as a chain of gpc_cell stages with a movable insertion point.
// Depends on gpc_cell.
module gpc_row_chain #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     shift_en,
   input  logic [$clog2(DEPTH)-1:0] insert_at,
   input  logic [WIDTH-1:0]         din,
   output logic [WIDTH-1:0]         dout
);

   localparam int IDX_BITS = $clog2(DEPTH);

   logic [WIDTH-1:0] tap [DEPTH];

   // A count enters at insert_at and reaches the last cell after as many
   // shifts as there are columns, just when the cell below it is processed.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic             load;
      logic [WIDTH-1:0] prev;

      assign load = (IDX_BITS'(i) == insert_at);
      if (i == 0) begin : g_head
         assign prev = din;
      end else begin : g_body
         assign prev = tap[i-1];
      end

      gpc_cell #(
         .WIDTH(WIDTH)
      ) u_cell (
         .clock      (clock),
         .shift_en   (shift_en),
         .load       (load),
         .new_value  (din),
         .prev_value (prev),
         .value      (tap[i])
      );
   end

   assign dout = tap[DEPTH-1];

endmodule

// File: verif/grid_path_count_blocked_test.sv
// Self-checking testbench for the grid path counter: directed table, a saturating
// grid, a long result stall, then random grids and mid-grid rewrites.
// Depends on gpc_pkg, the gpc_if interfaces and grid_path_count_blocked.
`timescale 1ns / 1ps

module grid_path_count_blocked_test;

   localparam int MAX_COLS         = 256;
   localparam int MAX_ROWS         = 256;
   localparam int COUNT_BITS       = 64;
   localparam int COL_BITS         = $clog2(MAX_COLS);
   localparam int RESET_CYCLES     = 7;
   localparam int DRAIN_CYCLES     = 6;
   localparam int HOLD_CYCLES      = 400;
   localparam int RANDOM_CELLS     = 150;
   localparam int MIN_RANDOM_GRIDS = 12;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int MAX_REPORTS      = 10;

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      count_type path_count;
      logic      saturated;
   } grid_result_type;

   typedef enum {STEP_CELL, STEP_REG} step_kind_type;

   typedef struct {
      step_kind_type          kind;
      gpc_pkg::csr_index_type reg_index;
      logic [8:0]             reg_value;
      logic                   blocked;
      bit                     typed;
      grid_result_type        known_res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gpc_req_if                            req_chan ();
   gpc_rsp_if #(.COUNT_BITS(COUNT_BITS)) rsp_chan ();
   gpc_csr_if                            csr_chan ();

   grid_path_count_blocked #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .COUNT_BITS (COUNT_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan),
      .csr_if (csr_chan)
   );

   always #1 clock = ~clock;

   // Predicted counts of grids that are finished on the input side.
   grid_result_type pending_counts[$];

   int failures        = 0;
   int grids_checked   = 0;
   int rsp_hold_cycles = 0;
   bit no_idle         = 1'b0;

   // Shadow state of the path counter.
   count_type   row_counts[MAX_COLS];
   count_type   left_val;
   int unsigned cur_row;
   int unsigned cur_col;
   bit          sat_seen;
   logic [8:0]  rows_reg;
   logic [8:0]  cols_reg;

   function automatic int unsigned clamp_dim(input logic [8:0] v, input int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return 32'(v);
   endfunction

   function automatic void restart_grid();
      left_val = '0;
      cur_row  = 0;
      cur_col  = 0;
      sat_seen = 1'b0;
   endfunction

   function automatic void apply_reg(input gpc_pkg::csr_index_type idx, input logic [8:0] val);
      case (idx)
         gpc_pkg::CSR_GRID_ROWS: begin
            rows_reg = val;
            restart_grid();
         end
         gpc_pkg::CSR_GRID_COLS: begin
            cols_reg = val;
            restart_grid();
         end
         default: begin
         end
      endcase
   endfunction

   // Cells still needed to finish the current grid.
   function automatic int unsigned cells_left();
      int unsigned n_rows;
      int unsigned n_cols;
      n_rows = clamp_dim(rows_reg, MAX_ROWS);
      n_cols = clamp_dim(cols_reg, MAX_COLS);
      if (cur_row >= n_rows || cur_col >= n_cols) return n_rows * n_cols;
      return n_rows * n_cols - (cur_row * n_cols + cur_col);
   endfunction

   // One cell: above plus left with saturation, then advance the position.
   function automatic void count_cell(input logic blk, output bit last,
                                      output grid_result_type res);
      int unsigned         n_rows;
      int unsigned         n_cols;
      count_type           up_val;
      count_type           left_in;
      count_type           cell_val;
      logic [COUNT_BITS:0] sum;
      n_rows = clamp_dim(rows_reg, MAX_ROWS);
      n_cols = clamp_dim(cols_reg, MAX_COLS);
      if (cur_col >= n_cols || cur_row >= n_rows) restart_grid();
      up_val  = (cur_row > 0) ? row_counts[cur_col[COL_BITS-1:0]] : '0;
      left_in = (cur_col > 0) ? left_val : '0;
      if (blk) begin
         cell_val = '0;
      end else if (cur_row == 0 && cur_col == 0) begin
         cell_val = 1;
      end else begin
         sum = {1'b0, up_val} + {1'b0, left_in};
         if (sum[COUNT_BITS]) begin
            cell_val = '1;
            sat_seen = 1'b1;
         end else begin
            cell_val = sum[COUNT_BITS-1:0];
         end
      end
      row_counts[cur_col[COL_BITS-1:0]] = cell_val;
      left_val            = cell_val;
      last                = (cur_row == n_rows - 1) && (cur_col == n_cols - 1);
      res.path_count      = cell_val;
      res.saturated       = sat_seen;
      if (last) begin
         restart_grid();
      end else begin
         cur_col++;
         if (cur_col >= n_cols) begin
            cur_col = 0;
            cur_row++;
         end
      end
   endfunction

   function automatic stim_row_type cell_row(input logic blk);
      stim_row_type row;
      row.kind      = STEP_CELL;
      row.reg_index = gpc_pkg::CSR_GRID_ROWS;
      row.reg_value = '0;
      row.blocked   = blk;
      row.typed     = 1'b0;
      row.known_res = '0;
      return row;
   endfunction

   function automatic stim_row_type cell_row_typed(input logic blk, input count_type cnt,
                                                   input logic sat);
      stim_row_type row;
      row                      = cell_row(blk);
      row.typed                = 1'b1;
      row.known_res.path_count = cnt;
      row.known_res.saturated  = sat;
      return row;
   endfunction

   function automatic stim_row_type reg_row(input gpc_pkg::csr_index_type idx,
                                            input logic [8:0] val);
      stim_row_type row;
      row           = cell_row(1'b0);
      row.kind      = STEP_REG;
      row.reg_index = idx;
      row.reg_value = val;
      return row;
   endfunction

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("ERROR: %s", msg);
   endtask

   // Offer one cell item after a random gap and predict it once it is taken.
   task automatic send_cell(input logic blk, input bit typed,
                            input grid_result_type typed_res);
      int              gap;
      bit              last;
      grid_result_type res;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.blocked = blk;
      do @(posedge clock); while (!req_chan.ready);
      count_cell(blk, last, res);
      if (last) pending_counts.push_back(typed ? typed_res : res);
   endtask

   task automatic send_cells(input int unsigned n, input int unsigned permille);
      repeat (n) send_cell($urandom_range(0, 999) < permille, 1'b0, '0);
   endtask

   // Stop offering cells, let every predicted count arrive, then let the block settle.
   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input gpc_pkg::csr_index_type idx, input logic [8:0] val);
      @(negedge clock);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.data  = val;
      do @(posedge clock); while (!csr_chan.ready);
      apply_reg(idx, val);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic set_grid(input logic [8:0] rows_val, input logic [8:0] cols_val);
      wait_idle();
      write_reg(gpc_pkg::CSR_GRID_ROWS, rows_val);
      write_reg(gpc_pkg::CSR_GRID_COLS, cols_val);
   endtask

   // Result side: random stall per item, long hold on request, compare on accept.
   initial begin : result_sink
      int              stall;
      bit              got;
      grid_result_type want;
      rsp_chan.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 10);
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         got = 1'b0;
         while (!got && rsp_hold_cycles == 0) begin
            @(posedge clock);
            if (rsp_chan.valid) begin
               got = 1'b1;
               grids_checked++;
               if (pending_counts.size() == 0) begin
                  note_failure($sformatf("count %0d sat %0b arrived with none pending",
                                         rsp_chan.path_count, rsp_chan.saturated));
               end else begin
                  want = pending_counts.pop_front();
                  if (rsp_chan.path_count !== want.path_count ||
                      rsp_chan.saturated !== want.saturated) begin
                     note_failure($sformatf("count %0d sat %0b, expected count %0d sat %0b",
                                            rsp_chan.path_count, rsp_chan.saturated,
                                            want.path_count, want.saturated));
                  end
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      stim_row_type directed_rows[$];
      stim_row_type row;
      int unsigned  random_cells;
      int           grids_base;
      int unsigned  n;
      int unsigned  n_grids;
      int unsigned  permille;
      logic [8:0]   new_rows;
      logic [8:0]   new_cols;
      bit           wrote;
      bit           big_dims;

      req_chan.valid   = 1'b0;
      req_chan.blocked = 1'b0;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = gpc_pkg::CSR_GRID_ROWS;
      csr_chan.data    = '0;

      rows_reg = 9'd1;
      cols_reg = 9'd1;
      foreach (row_counts[i]) row_counts[i] = '0;
      restart_grid();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: one-cell grids from reset values and from zero registers,
      // small 2x2 grids, writes to unused indexes, a rewrite in mid-grid and a 2x3 grid.
      directed_rows.push_back(cell_row_typed(1'b0, 1, 1'b0));
      directed_rows.push_back(cell_row_typed(1'b1, 0, 1'b0));
      directed_rows.push_back(reg_row(gpc_pkg::CSR_GRID_ROWS, 9'd0));
      directed_rows.push_back(reg_row(gpc_pkg::CSR_GRID_COLS, 9'd0));
      directed_rows.push_back(cell_row_typed(1'b0, 1, 1'b0));
      directed_rows.push_back(reg_row(gpc_pkg::CSR_GRID_ROWS, 9'd2));
      directed_rows.push_back(reg_row(gpc_pkg::CSR_GRID_COLS, 9'd2));
      repeat (3) directed_rows.push_back(cell_row(1'b0));
      directed_rows.push_back(cell_row_typed(1'b0, 2, 1'b0));
      directed_rows.push_back(cell_row(1'b0));
      directed_rows.push_back(cell_row(1'b1));
      directed_rows.push_back(cell_row(1'b1));
      directed_rows.push_back(cell_row_typed(1'b0, 0, 1'b0));
      directed_rows.push_back(cell_row(1'b0));
      directed_rows.push_back(reg_row(gpc_pkg::CSR_UNUSED_TWO, 9'h1FF));
      directed_rows.push_back(cell_row(1'b0));
      directed_rows.push_back(cell_row(1'b0));
      directed_rows.push_back(cell_row_typed(1'b1, 0, 1'b0));
      directed_rows.push_back(cell_row(1'b0));
      directed_rows.push_back(reg_row(gpc_pkg::CSR_UNUSED_THR, 9'h000));
      directed_rows.push_back(reg_row(gpc_pkg::CSR_GRID_COLS, 9'd3));
      repeat (5) directed_rows.push_back(cell_row(1'b0));
      directed_rows.push_back(cell_row_typed(1'b0, 3, 1'b0));

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == STEP_REG) begin
            wait_idle();
            write_reg(row.reg_index, row.reg_value);
         end else begin
            send_cell(row.blocked, row.typed, row.known_res);
         end
      end

      // The smallest square open grid whose corner count no longer fits.
      set_grid(9'd35, 9'd35);
      send_cells(cells_left(), 0);

      // One-cell grids while the result side holds off, so the input stalls.
      set_grid(9'd1, 9'd1);
      no_idle         = 1'b1;
      rsp_hold_cycles = HOLD_CYCLES;
      send_cells(40, 300);
      no_idle = 1'b0;

      // Random phases of small grids, some cut off in mid-grid by the next rewrite.
      // Now and then one side gets zero, the maximum or a clamped value over a one-wide grid.
      random_cells = 0;
      grids_base   = grids_checked;
      while (random_cells < RANDOM_CELLS || grids_checked - grids_base < MIN_RANDOM_GRIDS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         wait_idle();
         if ($urandom_range(0, 5) == 0) begin
            if ($urandom_range(0, 1) == 0)
               write_reg(gpc_pkg::CSR_UNUSED_TWO, 9'($urandom_range(0, 511)));
            else
               write_reg(gpc_pkg::CSR_UNUSED_THR, 9'($urandom_range(0, 511)));
         end
         new_rows = 9'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 16 : 6));
         new_cols = 9'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 16 : 6));
         big_dims = 1'b0;
         if ($urandom_range(0, 9) == 0) begin
            big_dims = 1'b1;
            case ($urandom_range(0, 2))
               0: new_rows = 9'd0;
               1: new_rows = 9'd256;
               default: new_rows = 9'($urandom_range(257, 511));
            endcase
            new_cols = 9'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 0) begin
               new_cols = new_rows;
               new_rows = 9'($urandom_range(0, 1));
            end
         end
         wrote = 1'b0;
         if ($urandom_range(0, 3) != 0 || big_dims || clamp_dim(rows_reg, MAX_ROWS) > 16) begin
            write_reg(gpc_pkg::CSR_GRID_ROWS, new_rows);
            wrote = 1'b1;
         end
         if ($urandom_range(0, 3) != 0 || !wrote || big_dims ||
             clamp_dim(cols_reg, MAX_COLS) > 16)
            write_reg(gpc_pkg::CSR_GRID_COLS, new_cols);
         n_grids = big_dims ? 1 : $urandom_range(1, 4);
         repeat (n_grids) begin
            case ($urandom_range(0, 3))
               0: permille = 0;
               1: permille = 100;
               2: permille = 300;
               default: permille = 700;
            endcase
            n = cells_left();
            send_cells(n, permille);
            random_cells += n;
         end
         if (!big_dims && $urandom_range(0, 2) == 0 && cells_left() > 1) begin
            n = $urandom_range(1, cells_left() - 1);
            send_cells(n, 200);
            random_cells += n;
         end
      end
      no_idle = 1'b0;

      wait_idle();
      if (pending_counts.size() != 0)
         note_failure($sformatf("%0d counts never arrived", pending_counts.size()));

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/gpc_pkg.sv
hw/rtl/gpc_if.sv
hw/rtl/gpc_cell.sv
hw/rtl/gpc_row_chain.sv
hw/rtl/grid_path_count_blocked.sv
verif/grid_path_count_blocked_test.sv
